### rtl/dhcp_lte_pkg.sv
package dhcp_lte_pkg;

    localparam int MAC_W = 48;
    localparam int IP_W  = 32;
    localparam int OFF_W = 8;
    localparam int SLOT_OUT_W = 4;

    // request types
    localparam logic [2:0] REQ_DISCOVER  = 3'd0;
    localparam logic [2:0] REQ_INFORM    = 3'd1;
    localparam logic [2:0] REQ_REQUEST   = 3'd2;
    localparam logic [2:0] REQ_RELEASE   = 3'd3;
    localparam logic [2:0] REQ_DECLINE   = 3'd4;
    localparam logic [2:0] REQ_IP_BY_MAC = 3'd5;
    localparam logic [2:0] REQ_MAC_BY_IP = 3'd6;
    localparam logic [2:0] REQ_IGNORE    = 3'd7;

    // reply kinds
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_OFFER = 3'd1;
    localparam logic [2:0] KIND_ACK   = 3'd2;
    localparam logic [2:0] KIND_NAK   = 3'd3;
    localparam logic [2:0] KIND_HIT   = 3'd4;
    localparam logic [2:0] KIND_MISS  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_NET_PREFIX = 2'd0;
    localparam logic [1:0] CFG_NET_MASK   = 2'd1;
    localparam logic [1:0] CFG_FIRST_OFF  = 2'd2;

    localparam logic [IP_W-1:0]  RST_NET_PREFIX = 32'h0A00_0200;
    localparam logic [IP_W-1:0]  RST_NET_MASK   = 32'hFFFF_FF00;
    localparam logic [OFF_W-1:0] RST_FIRST_OFF  = 8'd15;

    typedef struct packed {
        logic clear;
        logic step;
        logic key_is_ip;
    } t_scan_ctl;

    typedef struct packed {
        logic            hit;
        logic            free;
        logic [MAC_W-1:0] hit_mac;
        logic [IP_W-1:0]  hit_ip;
    } t_scan_stat;

endpackage

### rtl/dhcp_lte_ram.sv
module dhcp_lte_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/dhcp_lte_scan.sv
module dhcp_lte_scan #(
    parameter int SLOT_W = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dhcp_lte_pkg::t_scan_ctl          i_ctl,
    input  logic [SLOT_W-1:0]                i_idx,
    input  logic                             i_ent_valid,
    input  logic [dhcp_lte_pkg::MAC_W-1:0]   i_ent_mac,
    input  logic [dhcp_lte_pkg::IP_W-1:0]    i_ent_ip,
    input  logic [dhcp_lte_pkg::MAC_W-1:0]   i_key_mac,
    input  logic [dhcp_lte_pkg::IP_W-1:0]    i_key_ip,
    output dhcp_lte_pkg::t_scan_stat         o_stat,
    output logic [SLOT_W-1:0]                o_hit_slot,
    output logic [SLOT_W-1:0]                o_free_slot
);
    logic                           r_hit;
    logic                           r_free;
    logic [SLOT_W-1:0]              r_hit_slot;
    logic [SLOT_W-1:0]              r_free_slot;
    logic [dhcp_lte_pkg::MAC_W-1:0] r_hit_mac;
    logic [dhcp_lte_pkg::IP_W-1:0]  r_hit_ip;
    logic [dhcp_lte_pkg::MAC_W-1:0] cmp_a;
    logic [dhcp_lte_pkg::MAC_W-1:0] cmp_b;
    logic                           match;

    // one comparator serves both mac and ip keys
    assign cmp_a = i_ctl.key_is_ip ? {16'd0, i_ent_ip} : i_ent_mac;
    assign cmp_b = i_ctl.key_is_ip ? {16'd0, i_key_ip} : i_key_mac;
    assign match = i_ent_valid && (cmp_a == cmp_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_ctl.step) begin
            // lowest slot wins for both searches
            if (match && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (!i_ent_valid && !r_free) begin
                r_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && match && !r_hit) begin
            r_hit_slot <= i_idx;
            r_hit_mac  <= i_ent_mac;
            r_hit_ip   <= i_ent_ip;
        end
        if (i_ctl.step && !i_ent_valid && !r_free) begin
            r_free_slot <= i_idx;
        end
    end

    assign o_stat.hit     = r_hit;
    assign o_stat.free    = r_free;
    assign o_stat.hit_mac = r_hit_mac;
    assign o_stat.hit_ip  = r_hit_ip;
    assign o_hit_slot     = r_hit_slot;
    assign o_free_slot    = r_free_slot;
endmodule

### rtl/dhcp_lease_table_engine.sv
// an accepted item walks the scan, drain and decide states; the result strobe is registered from decide
// a new item is taken only back in idle, busy is high meanwhile
// the table scan reads one slot per cycle through the single ram read port
// every item yields exactly one result beat, shown for one cycle; the receiver cannot stall
// synchronous active-low reset clears all slot valid bits and loads register defaults
// config writes are always taken, one per cycle
module dhcp_lease_table_engine #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [2:0]                       i_req_type,
    input  logic [dhcp_lte_pkg::MAC_W-1:0]   i_client_mac,
    input  logic [dhcp_lte_pkg::IP_W-1:0]    i_client_addr,
    input  logic [dhcp_lte_pkg::IP_W-1:0]    i_requested_addr,
    input  logic                             i_requested_present,
    input  logic                             i_server_id_present,
    input  logic                             i_broadcast_flag,
    output logic                             o_valid,
    output logic [2:0]                       o_reply_kind,
    output logic [dhcp_lte_pkg::IP_W-1:0]    o_result_addr,
    output logic [dhcp_lte_pkg::MAC_W-1:0]   o_result_mac,
    output logic                             o_dest_broadcast,
    output logic [dhcp_lte_pkg::SLOT_OUT_W-1:0] o_entry_slot,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [31:0]                      i_cfg_data
);
    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ENT_W  = dhcp_lte_pkg::MAC_W + dhcp_lte_pkg::IP_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0]                       r_state, n_state;
    logic [SLOT_W-1:0]                r_idx, n_idx;
    logic                             r_rd_vld;
    logic [SLOT_W-1:0]                r_rd_idx;
    logic [TABLE_ENTRIES-1:0]         r_valid;

    logic [dhcp_lte_pkg::IP_W-1:0]    r_net_prefix;
    logic [dhcp_lte_pkg::IP_W-1:0]    r_net_mask;
    logic [dhcp_lte_pkg::OFF_W-1:0]   r_first_off;

    logic [2:0]                       r_req_type;
    logic [dhcp_lte_pkg::MAC_W-1:0]   r_client_mac;
    logic [dhcp_lte_pkg::IP_W-1:0]    r_client_addr;
    logic [dhcp_lte_pkg::IP_W-1:0]    r_requested_addr;
    logic                             r_rpres;
    logic                             r_spres;
    logic                             r_bcast;

    logic                             r_o_valid;
    logic [2:0]                       r_o_kind;
    logic [dhcp_lte_pkg::IP_W-1:0]    r_o_addr;
    logic [dhcp_lte_pkg::MAC_W-1:0]   r_o_mac;
    logic                             r_o_bcast;
    logic [dhcp_lte_pkg::SLOT_OUT_W-1:0] r_o_slot;

    logic                             accept;
    logic [ENT_W-1:0]                 ram_rdata;
    dhcp_lte_pkg::t_scan_ctl          scan_ctl;
    dhcp_lte_pkg::t_scan_stat         scan_stat;
    logic [SLOT_W-1:0]                hit_slot;
    logic [SLOT_W-1:0]                free_slot;

    logic                             wr_en;
    logic [SLOT_W-1:0]                wr_slot;
    logic [dhcp_lte_pkg::MAC_W-1:0]   wr_mac;
    logic [dhcp_lte_pkg::IP_W-1:0]    wr_ip;
    logic                             clr_en;
    logic [2:0]                       d_kind;
    logic                             d_use_slot;
    logic [SLOT_W-1:0]                d_slot;
    logic [dhcp_lte_pkg::IP_W-1:0]    d_addr;
    logic [dhcp_lte_pkg::MAC_W-1:0]   d_mac;
    logic [dhcp_lte_pkg::IP_W-1:0]    alloc_ip;
    logic                             raddr_on_net;
    logic                             caddr_on_net;
    logic [31:0]                      slot_wide;

    assign accept      = i_start && !o_busy;
    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_net_prefix <= dhcp_lte_pkg::RST_NET_PREFIX;
            r_net_mask   <= dhcp_lte_pkg::RST_NET_MASK;
            r_first_off  <= dhcp_lte_pkg::RST_FIRST_OFF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dhcp_lte_pkg::CFG_NET_PREFIX: r_net_prefix <= i_cfg_data;
                dhcp_lte_pkg::CFG_NET_MASK:   r_net_mask   <= i_cfg_data;
                dhcp_lte_pkg::CFG_FIRST_OFF:  r_first_off  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                    n_idx   = '0;
                end
            end
            ST_SCAN: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_SLOT) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_rd_vld <= (r_state == ST_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (accept) begin
            r_req_type       <= i_req_type;
            r_client_mac     <= i_client_mac;
            r_client_addr    <= i_client_addr;
            r_requested_addr <= i_requested_addr;
            r_rpres          <= i_requested_present;
            r_spres          <= i_server_id_present;
            r_bcast          <= i_broadcast_flag;
        end
    end

    dhcp_lte_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_slot),
        .i_wdata ({wr_mac, wr_ip}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign scan_ctl.clear     = accept;
    assign scan_ctl.step      = r_rd_vld;
    assign scan_ctl.key_is_ip = r_req_type inside {dhcp_lte_pkg::REQ_RELEASE,
                                                   dhcp_lte_pkg::REQ_MAC_BY_IP,
                                                   dhcp_lte_pkg::REQ_DECLINE};

    dhcp_lte_scan #(
        .SLOT_W (SLOT_W)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_idx       (r_rd_idx),
        .i_ent_valid (r_valid[r_rd_idx]),
        .i_ent_mac   (ram_rdata[ENT_W-1:dhcp_lte_pkg::IP_W]),
        .i_ent_ip    (ram_rdata[dhcp_lte_pkg::IP_W-1:0]),
        .i_key_mac   (r_client_mac),
        .i_key_ip    ((r_req_type == dhcp_lte_pkg::REQ_DECLINE) ? r_requested_addr
                                                                 : r_client_addr),
        .o_stat      (scan_stat),
        .o_hit_slot  (hit_slot),
        .o_free_slot (free_slot)
    );

    assign alloc_ip     = r_net_prefix | (32'(free_slot) + 32'(r_first_off));
    assign raddr_on_net = ((r_requested_addr & r_net_mask) == r_net_prefix);
    assign caddr_on_net = ((r_client_addr & r_net_mask) == r_net_prefix);

    always_comb begin
        wr_en      = 1'b0;
        wr_slot    = free_slot;
        wr_mac     = r_client_mac;
        wr_ip      = r_requested_addr;
        clr_en     = 1'b0;
        d_kind     = dhcp_lte_pkg::KIND_NONE;
        d_use_slot = 1'b0;
        d_slot     = hit_slot;
        d_addr     = '0;
        d_mac      = '0;
        case (r_req_type)
            dhcp_lte_pkg::REQ_DISCOVER: begin
                if (scan_stat.hit) begin
                    d_kind     = dhcp_lte_pkg::KIND_OFFER;
                    d_use_slot = 1'b1;
                    d_addr     = scan_stat.hit_ip;
                end else if (scan_stat.free) begin
                    wr_en      = 1'b1;
                    wr_ip      = alloc_ip;
                    d_kind     = dhcp_lte_pkg::KIND_OFFER;
                    d_use_slot = 1'b1;
                    d_slot     = free_slot;
                    d_addr     = alloc_ip;
                end
            end
            dhcp_lte_pkg::REQ_INFORM: begin
                if (scan_stat.hit) begin
                    d_kind     = dhcp_lte_pkg::KIND_ACK;
                    d_use_slot = 1'b1;
                    d_addr     = scan_stat.hit_ip;
                end
            end
            dhcp_lte_pkg::REQ_REQUEST: begin
                if (r_spres) begin
                    // selecting
                    if (scan_stat.hit && r_rpres && r_client_addr == '0) begin
                        d_kind     = dhcp_lte_pkg::KIND_ACK;
                        d_use_slot = 1'b1;
                        d_addr     = scan_stat.hit_ip;
                    end
                end else if (r_rpres) begin
                    // init-reboot: the lease, or a new slot, takes requested_addr
                    if (r_client_addr != '0) begin
                        d_kind = dhcp_lte_pkg::KIND_NONE;
                    end else if (!raddr_on_net) begin
                        d_kind = dhcp_lte_pkg::KIND_NAK;
                    end else if (scan_stat.hit || scan_stat.free) begin
                        wr_en      = 1'b1;
                        wr_slot    = scan_stat.hit ? hit_slot : free_slot;
                        d_kind     = dhcp_lte_pkg::KIND_ACK;
                        d_use_slot = 1'b1;
                        d_slot     = wr_slot;
                        d_addr     = r_requested_addr;
                    end
                end else if (r_bcast) begin
                    // rebinding
                    if (scan_stat.hit) begin
                        d_kind     = dhcp_lte_pkg::KIND_ACK;
                        d_use_slot = 1'b1;
                        d_addr     = scan_stat.hit_ip;
                    end
                end else if (r_client_addr != '0) begin
                    // renewing
                    if (scan_stat.hit) begin
                        d_kind     = dhcp_lte_pkg::KIND_ACK;
                        d_use_slot = 1'b1;
                        d_addr     = scan_stat.hit_ip;
                    end else if (!caddr_on_net) begin
                        d_kind = dhcp_lte_pkg::KIND_NAK;
                    end else if (scan_stat.free) begin
                        wr_en      = 1'b1;
                        wr_ip      = r_client_addr;
                        d_kind     = dhcp_lte_pkg::KIND_ACK;
                        d_use_slot = 1'b1;
                        d_slot     = free_slot;
                        d_addr     = r_client_addr;
                    end
                end
            end
            dhcp_lte_pkg::REQ_RELEASE: begin
                clr_en = scan_stat.hit;
            end
            dhcp_lte_pkg::REQ_DECLINE: begin
                if (r_rpres && !scan_stat.hit && scan_stat.free) begin
                    wr_en  = 1'b1;
                    wr_mac = '0;
                end
            end
            dhcp_lte_pkg::REQ_IP_BY_MAC: begin
                if (scan_stat.hit) begin
                    d_kind     = dhcp_lte_pkg::KIND_HIT;
                    d_use_slot = 1'b1;
                    d_addr     = scan_stat.hit_ip;
                end else begin
                    d_kind = dhcp_lte_pkg::KIND_MISS;
                end
            end
            dhcp_lte_pkg::REQ_MAC_BY_IP: begin
                if (scan_stat.hit) begin
                    d_kind     = dhcp_lte_pkg::KIND_HIT;
                    d_use_slot = 1'b1;
                    d_addr     = scan_stat.hit_ip;
                    d_mac      = scan_stat.hit_mac;
                end else begin
                    d_kind = dhcp_lte_pkg::KIND_MISS;
                end
            end
            default: ;
        endcase
        if (r_state != ST_DECIDE) begin
            wr_en  = 1'b0;
            clr_en = 1'b0;
        end
    end

    assign slot_wide = 32'(d_slot);

    // freed or never used slots are told apart by their valid bit; a release clears only that bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_slot] <= 1'b1;
        end else if (clr_en) begin
            r_valid[hit_slot] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= (r_state == ST_DECIDE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DECIDE) begin
            r_o_kind  <= d_kind;
            r_o_addr  <= d_addr;
            r_o_mac   <= d_mac;
            r_o_bcast <= (d_kind == dhcp_lte_pkg::KIND_NAK) ||
                         (r_bcast && (d_kind == dhcp_lte_pkg::KIND_OFFER ||
                                      d_kind == dhcp_lte_pkg::KIND_ACK));
            r_o_slot  <= d_use_slot ? slot_wide[dhcp_lte_pkg::SLOT_OUT_W-1:0] : '0;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_reply_kind     = r_o_kind;
    assign o_result_addr    = r_o_addr;
    assign o_result_mac     = r_o_mac;
    assign o_dest_broadcast = r_o_bcast;
    assign o_entry_slot     = r_o_slot;

`ifndef NO_ASSERTIONS
    a_strobe_after_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> $past(r_state == ST_DECIDE))
        else $error("result strobe without a decide cycle");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == ST_SCAN && r_idx == '0))
        else $error("accepted item did not start a scan at slot zero");

    a_drain_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> r_rd_vld)
        else $error("last slot read missing in drain");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (o_reply_kind <= dhcp_lte_pkg::KIND_MISS))
        else $error("reply kind out of range");
`endif
endmodule

### sim/tb.sv
module tb;

    localparam int TBL = 16;

    typedef struct packed {
        logic [2:0]                     req_type;
        logic [dhcp_lte_pkg::MAC_W-1:0] mac;
        logic [dhcp_lte_pkg::IP_W-1:0]  caddr;
        logic [dhcp_lte_pkg::IP_W-1:0]  raddr;
        logic                           rpres;
        logic                           spres;
        logic                           bcast;
    } t_dhcp_msg;

    typedef struct packed {
        logic [2:0]                          kind;
        logic [dhcp_lte_pkg::IP_W-1:0]       addr;
        logic [dhcp_lte_pkg::MAC_W-1:0]      mac;
        logic                                dbc;
        logic [dhcp_lte_pkg::SLOT_OUT_W-1:0] slot;
    } t_lease_reply;

    logic                                i_clk;
    logic                                i_rst_n = 1'b0;
    logic                                i_start = 1'b0;
    logic                                o_busy;
    logic [2:0]                          i_req_type = '0;
    logic [dhcp_lte_pkg::MAC_W-1:0]      i_client_mac = '0;
    logic [dhcp_lte_pkg::IP_W-1:0]       i_client_addr = '0;
    logic [dhcp_lte_pkg::IP_W-1:0]       i_requested_addr = '0;
    logic                                i_requested_present = 1'b0;
    logic                                i_server_id_present = 1'b0;
    logic                                i_broadcast_flag = 1'b0;
    logic                                o_valid;
    logic [2:0]                          o_reply_kind;
    logic [dhcp_lte_pkg::IP_W-1:0]       o_result_addr;
    logic [dhcp_lte_pkg::MAC_W-1:0]      o_result_mac;
    logic                                o_dest_broadcast;
    logic [dhcp_lte_pkg::SLOT_OUT_W-1:0] o_entry_slot;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [1:0]                          i_cfg_index = '0;
    logic [31:0]                         i_cfg_data = '0;

    dhcp_lease_table_engine #(
        .TABLE_ENTRIES(TBL)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .o_busy(o_busy),
        .i_req_type(i_req_type),
        .i_client_mac(i_client_mac),
        .i_client_addr(i_client_addr),
        .i_requested_addr(i_requested_addr),
        .i_requested_present(i_requested_present),
        .i_server_id_present(i_server_id_present),
        .i_broadcast_flag(i_broadcast_flag),
        .o_valid(o_valid),
        .o_reply_kind(o_reply_kind),
        .o_result_addr(o_result_addr),
        .o_result_mac(o_result_mac),
        .o_dest_broadcast(o_dest_broadcast),
        .o_entry_slot(o_entry_slot),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // lease table mirror and register copies
    logic [dhcp_lte_pkg::IP_W-1:0]  cfg_prefix = dhcp_lte_pkg::RST_NET_PREFIX;
    logic [dhcp_lte_pkg::IP_W-1:0]  cfg_mask   = dhcp_lte_pkg::RST_NET_MASK;
    logic [dhcp_lte_pkg::OFF_W-1:0] cfg_offset = dhcp_lte_pkg::RST_FIRST_OFF;
    logic                           tbl_valid [TBL];
    logic [dhcp_lte_pkg::MAC_W-1:0] tbl_mac [TBL];
    logic [dhcp_lte_pkg::IP_W-1:0]  tbl_ip [TBL];

    t_lease_reply                   pending_replies[$];
    logic [dhcp_lte_pkg::MAC_W-1:0] mac_pool [28];
    int               mismatches = 0;
    int               items_sent = 0;
    int               type_sent [8];
    int               kind_seen [8];
    int               full_table_hits = 0;
    int               burst_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    function automatic int find_by_mac(logic [dhcp_lte_pkg::MAC_W-1:0] mac);
        for (int i = 0; i < TBL; i++)
            if (tbl_valid[i] && tbl_mac[i] == mac) return i;
        return -1;
    endfunction

    function automatic int find_by_ip(logic [dhcp_lte_pkg::IP_W-1:0] ip);
        for (int i = 0; i < TBL; i++)
            if (tbl_valid[i] && tbl_ip[i] == ip) return i;
        return -1;
    endfunction

    function automatic int take_free_slot();
        for (int i = 0; i < TBL; i++) begin
            if (!tbl_valid[i]) begin
                tbl_valid[i] = 1'b1;
                tbl_mac[i] = '0;
                tbl_ip[i] = '0;
                return i;
            end
        end
        full_table_hits++;
        return -1;
    endfunction

    function automatic bit on_subnet(logic [dhcp_lte_pkg::IP_W-1:0] a);
        return (a & cfg_mask) == cfg_prefix;
    endfunction

    // updates the mirror and returns the reply the block must give
    function automatic t_lease_reply serve_lease(t_dhcp_msg m);
        t_lease_reply r;
        int s;
        int slot;
        r = '0;
        slot = -1;
        s = -1;
        case (m.req_type)
            dhcp_lte_pkg::REQ_DISCOVER: begin
                s = find_by_mac(m.mac);
                if (s < 0) begin
                    s = take_free_slot();
                    if (s >= 0) begin
                        tbl_mac[s] = m.mac;
                        tbl_ip[s] = cfg_prefix | (32'(s) + 32'(cfg_offset));
                    end
                end
                if (s >= 0) begin
                    r.kind = dhcp_lte_pkg::KIND_OFFER;
                    slot = s;
                end
            end
            dhcp_lte_pkg::REQ_INFORM: begin
                s = find_by_mac(m.mac);
                if (s >= 0) begin
                    r.kind = dhcp_lte_pkg::KIND_ACK;
                    slot = s;
                end
            end
            dhcp_lte_pkg::REQ_REQUEST: begin
                s = find_by_mac(m.mac);
                if (m.spres) begin
                    if (s >= 0 && m.rpres && m.caddr == 0) begin
                        r.kind = dhcp_lte_pkg::KIND_ACK;
                        slot = s;
                    end
                end else if (m.rpres) begin
                    if (m.caddr == 0) begin
                        if (!on_subnet(m.raddr)) begin
                            r.kind = dhcp_lte_pkg::KIND_NAK;
                        end else begin
                            if (s < 0) s = take_free_slot();
                            if (s >= 0) begin
                                tbl_mac[s] = m.mac;
                                tbl_ip[s] = m.raddr;
                                r.kind = dhcp_lte_pkg::KIND_ACK;
                                slot = s;
                            end
                        end
                    end
                end else if (m.bcast) begin
                    if (s >= 0) begin
                        r.kind = dhcp_lte_pkg::KIND_ACK;
                        slot = s;
                    end
                end else if (m.caddr != 0) begin
                    // renewing client unknown to the table
                    if (s < 0) begin
                        if (!on_subnet(m.caddr)) begin
                            r.kind = dhcp_lte_pkg::KIND_NAK;
                        end else begin
                            s = take_free_slot();
                            if (s >= 0) begin
                                tbl_mac[s] = m.mac;
                                tbl_ip[s] = m.caddr;
                            end
                        end
                    end
                    if (s >= 0) begin
                        r.kind = dhcp_lte_pkg::KIND_ACK;
                        slot = s;
                    end
                end
            end
            dhcp_lte_pkg::REQ_RELEASE: begin
                s = find_by_ip(m.caddr);
                if (s >= 0) begin
                    tbl_valid[s] = 1'b0;
                    tbl_mac[s] = '0;
                    tbl_ip[s] = '0;
                end
            end
            dhcp_lte_pkg::REQ_DECLINE: begin
                if (m.rpres && find_by_ip(m.raddr) < 0) begin
                    s = take_free_slot();
                    if (s >= 0) tbl_ip[s] = m.raddr;
                end
            end
            dhcp_lte_pkg::REQ_IP_BY_MAC: begin
                s = find_by_mac(m.mac);
                if (s >= 0) begin
                    r.kind = dhcp_lte_pkg::KIND_HIT;
                    slot = s;
                    r.addr = tbl_ip[s];
                end else begin
                    r.kind = dhcp_lte_pkg::KIND_MISS;
                end
            end
            dhcp_lte_pkg::REQ_MAC_BY_IP: begin
                s = find_by_ip(m.caddr);
                if (s >= 0) begin
                    r.kind = dhcp_lte_pkg::KIND_HIT;
                    slot = s;
                    r.addr = tbl_ip[s];
                    r.mac = tbl_mac[s];
                end else begin
                    r.kind = dhcp_lte_pkg::KIND_MISS;
                end
            end
            default: ;
        endcase
        if (r.kind == dhcp_lte_pkg::KIND_OFFER || r.kind == dhcp_lte_pkg::KIND_ACK) begin
            r.addr = tbl_ip[slot];
            r.dbc = m.bcast;
        end else if (r.kind == dhcp_lte_pkg::KIND_NAK) begin
            r.dbc = 1'b1;
        end
        if (slot >= 0) r.slot = slot[dhcp_lte_pkg::SLOT_OUT_W-1:0];
        return r;
    endfunction

    // result checking, one beat per strobe
    always @(posedge i_clk) begin
        t_lease_reply got;
        t_lease_reply want;
        if (i_rst_n && o_valid === 1'b1) begin
            got = {o_reply_kind, o_result_addr, o_result_mac, o_dest_broadcast, o_entry_slot};
            kind_seen[o_reply_kind]++;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply beat: kind %0d addr %h", o_reply_kind,
                             o_result_addr);
            end else begin
                want = pending_replies.pop_front();
                if (got.kind !== want.kind || got.addr !== want.addr || got.mac !== want.mac
                        || got.dbc !== want.dbc || got.slot !== want.slot) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("reply mismatch at %0t", $realtime);
                        $display("  expected kind %0d addr %h mac %h bcast %0d slot %0d",
                                 want.kind, want.addr, want.mac, want.dbc, want.slot);
                        $display("  actual   kind %0d addr %h mac %h bcast %0d slot %0d",
                                 got.kind, got.addr, got.mac, got.dbc, got.slot);
                    end
                end
            end
        end
    end

    task automatic send_msg(input t_dhcp_msg m);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 18);
            if ($urandom_range(0, 11) == 0) burst_left = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            i_start <= 1'b0;
            // mostly idle after the block frees up, sometimes raise start while busy
            if ($urandom_range(0, 3) != 0) begin
                do @(posedge i_clk); while (o_busy !== 1'b0);
                repeat (gap - 1) @(posedge i_clk);
            end else begin
                repeat (gap) @(posedge i_clk);
            end
        end
        i_start             <= 1'b1;
        i_req_type          <= m.req_type;
        i_client_mac        <= m.mac;
        i_client_addr       <= m.caddr;
        i_requested_addr    <= m.raddr;
        i_requested_present <= m.rpres;
        i_server_id_present <= m.spres;
        i_broadcast_flag    <= m.bcast;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        pending_replies.push_back(serve_lease(m));
        items_sent++;
        type_sent[m.req_type]++;
    endtask

    task automatic settle();
        i_start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (TBL + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        case (idx)
            dhcp_lte_pkg::CFG_NET_PREFIX: cfg_prefix = val;
            dhcp_lte_pkg::CFG_NET_MASK:   cfg_mask = val;
            dhcp_lte_pkg::CFG_FIRST_OFF:  cfg_offset = val[dhcp_lte_pkg::OFF_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [31:0] prefix, input logic [31:0] mask,
                                  input logic [7:0] offset);
        settle();
        write_reg(dhcp_lte_pkg::CFG_NET_PREFIX, prefix);
        write_reg(dhcp_lte_pkg::CFG_NET_MASK, mask);
        write_reg(dhcp_lte_pkg::CFG_FIRST_OFF, {24'h0, offset});
    endtask

    function automatic t_dhcp_msg msg(logic [2:0] t, logic [dhcp_lte_pkg::MAC_W-1:0] mac,
                                      logic [dhcp_lte_pkg::IP_W-1:0] caddr,
                                      logic [dhcp_lte_pkg::IP_W-1:0] raddr,
                                      logic rp, logic sp, logic bc);
        return '{req_type: t, mac: mac, caddr: caddr, raddr: raddr, rpres: rp, spres: sp,
                 bcast: bc};
    endfunction

    function automatic logic [dhcp_lte_pkg::MAC_W-1:0] pick_mac();
        if ($urandom_range(0, 4) != 0) return mac_pool[$urandom_range(0, 27)];
        return dhcp_lte_pkg::MAC_W'({$urandom, $urandom});
    endfunction

    function automatic logic [dhcp_lte_pkg::IP_W-1:0] leased_addr();
        int base;
        int j;
        base = $urandom_range(0, TBL - 1);
        for (int i = 0; i < TBL; i++) begin
            j = (base + i) % TBL;
            if (tbl_valid[j]) return tbl_ip[j];
        end
        return $urandom;
    endfunction

    function automatic logic [dhcp_lte_pkg::IP_W-1:0] pick_addr();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40) return leased_addr();
        if (k < 75) return (cfg_prefix & cfg_mask) | ($urandom & ~cfg_mask);
        if (k < 90) return $urandom;
        return '0;
    endfunction

    // mostly well-formed messages against the current table, some noise
    function automatic t_dhcp_msg random_msg(bit shrink);
        t_dhcp_msg m;
        int k;
        int shape;
        m.req_type = 3'($urandom_range(0, 7));
        m.mac      = dhcp_lte_pkg::MAC_W'({$urandom, $urandom});
        m.caddr    = $urandom;
        m.raddr    = $urandom;
        m.rpres    = 1'($urandom_range(0, 1));
        m.spres    = 1'($urandom_range(0, 1));
        m.bcast    = 1'($urandom_range(0, 1));
        k = $urandom_range(0, 99);
        if (shrink && $urandom_range(0, 3) == 0) k = 60;
        if (k < 20) begin
            m.req_type = dhcp_lte_pkg::REQ_DISCOVER;
            m.mac = pick_mac();
        end else if (k < 50) begin
            m.req_type = dhcp_lte_pkg::REQ_REQUEST;
            m.mac = pick_mac();
            shape = $urandom_range(0, 9);
            if (shape < 3) begin
                // selecting, sometimes broken
                m.spres = 1'b1;
                m.rpres = ($urandom_range(0, 7) != 0);
                m.caddr = ($urandom_range(0, 7) != 0) ? '0 : pick_addr();
                m.raddr = pick_addr();
            end else if (shape < 6) begin
                m.spres = 1'b0;
                m.rpres = 1'b1;
                m.caddr = ($urandom_range(0, 5) != 0) ? '0 : pick_addr();
                m.raddr = pick_addr();
            end else if (shape < 8) begin
                m.spres = 1'b0;
                m.rpres = 1'b0;
                m.bcast = 1'b0;
                m.caddr = pick_addr();
            end else if (shape < 9) begin
                m.spres = 1'b0;
                m.rpres = 1'b0;
                m.bcast = 1'b1;
                m.caddr = pick_addr();
            end
        end else if (k < 56) begin
            m.req_type = dhcp_lte_pkg::REQ_INFORM;
            m.mac = pick_mac();
        end else if (k < 64) begin
            m.req_type = dhcp_lte_pkg::REQ_RELEASE;
            m.caddr = ($urandom_range(0, 3) != 0) ? leased_addr() : pick_addr();
        end else if (k < 70) begin
            m.req_type = dhcp_lte_pkg::REQ_DECLINE;
            m.rpres = ($urandom_range(0, 5) != 0);
            m.raddr = pick_addr();
        end else if (k < 81) begin
            m.req_type = dhcp_lte_pkg::REQ_IP_BY_MAC;
            m.mac = pick_mac();
        end else if (k < 92) begin
            m.req_type = dhcp_lte_pkg::REQ_MAC_BY_IP;
            m.caddr = pick_addr();
        end else if (k < 94) begin
            m.req_type = dhcp_lte_pkg::REQ_IGNORE;
        end
        return m;
    endfunction

    localparam logic [dhcp_lte_pkg::MAC_W-1:0] MAC_A = 48'h0200_0000_00A1;
    localparam logic [dhcp_lte_pkg::MAC_W-1:0] MAC_C = 48'h0200_0000_00C3;
    localparam logic [dhcp_lte_pkg::MAC_W-1:0] MAC_D = 48'h0200_0000_00D4;
    localparam logic [dhcp_lte_pkg::MAC_W-1:0] MAC_E = 48'h0200_0000_00E5;

    task automatic test_offer_and_lookup();
        send_msg(msg(dhcp_lte_pkg::REQ_DISCOVER, MAC_A, '0, '0, 1'b0, 1'b0, 1'b0));
        send_msg(msg(dhcp_lte_pkg::REQ_DISCOVER, MAC_A, '0, '0, 1'b0, 1'b0, 1'b1));
        send_msg(msg(dhcp_lte_pkg::REQ_DISCOVER, '1, '1, '1, 1'b1, 1'b1, 1'b1));
        send_msg(msg(dhcp_lte_pkg::REQ_DISCOVER, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        send_msg(msg(dhcp_lte_pkg::REQ_INFORM, MAC_A, 32'h0A00_020F, '0, 1'b0, 1'b0, 1'b1));
        send_msg(msg(dhcp_lte_pkg::REQ_INFORM, MAC_C, '0, '0, 1'b0, 1'b0, 1'b0));
        send_msg(msg(dhcp_lte_pkg::REQ_IP_BY_MAC, MAC_A, '0, '0, 1'b0, 1'b0, 1'b0));
        send_msg(msg(dhcp_lte_pkg::REQ_IP_BY_MAC, MAC_C, '0, '0, 1'b0, 1'b0, 1'b0));
        send_msg(msg(dhcp_lte_pkg::REQ_MAC_BY_IP, '0, 32'h0A00_020F, '0, 1'b0, 1'b0, 1'b0));
        send_msg(msg(dhcp_lte_pkg::REQ_MAC_BY_IP, '0, '1, '0, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_request_paths();
        // selecting
        send_msg(msg(dhcp_lte_pkg::REQ_REQUEST, MAC_A, '0, 32'h0A00_020F,
                     1'b1, 1'b1, 1'b1));
        send_msg(msg(dhcp_lte_pkg::REQ_REQUEST, MAC_A, 32'h0A00_020F, 32'h0A00_020F,
                     1'b1, 1'b1, 1'b0));
        send_msg(msg(dhcp_lte_pkg::REQ_REQUEST, MAC_C, '0, 32'h0A00_0230,
                     1'b1, 1'b1, 1'b0));
        // init-reboot
        send_msg(msg(dhcp_lte_pkg::REQ_REQUEST, MAC_C, '0, 32'h0A00_0264,
                     1'b1, 1'b0, 1'b0));
        send_msg(msg(dhcp_lte_pkg::REQ_REQUEST, MAC_D, '0, 32'hC0A8_0001,
                     1'b1, 1'b0, 1'b1));
        send_msg(msg(dhcp_lte_pkg::REQ_REQUEST, MAC_D, 32'h0A00_0201, 32'h0A00_0201,
                     1'b1, 1'b0, 1'b0));
        // renewing
        send_msg(msg(dhcp_lte_pkg::REQ_REQUEST, MAC_D, '0, '0, 1'b0, 1'b0, 1'b0));
        send_msg(msg(dhcp_lte_pkg::REQ_REQUEST, MAC_D, 32'h0A00_0270, '0,
                     1'b0, 1'b0, 1'b0));
        send_msg(msg(dhcp_lte_pkg::REQ_REQUEST, MAC_E, 32'h0B00_0001, '0,
                     1'b0, 1'b0, 1'b0));
        // rebinding
        send_msg(msg(dhcp_lte_pkg::REQ_REQUEST, MAC_A, 32'h0A00_020F, '0,
                     1'b0, 1'b0, 1'b1));
        send_msg(msg(dhcp_lte_pkg::REQ_REQUEST, MAC_E, 32'h0A00_0271, '0,
                     1'b0, 1'b0, 1'b1));
    endtask

    task automatic test_release_decline_ignore();
        send_msg(msg(dhcp_lte_pkg::REQ_RELEASE, MAC_E, 32'h0A00_020F, '0, 1'b0, 1'b0, 1'b0));
        send_msg(msg(dhcp_lte_pkg::REQ_DECLINE, MAC_E, '0, 32'h0A00_0250, 1'b0, 1'b0, 1'b0));
        send_msg(msg(dhcp_lte_pkg::REQ_DECLINE, MAC_E, '0, 32'h0A00_0250, 1'b1, 1'b0, 1'b0));
        send_msg(msg(dhcp_lte_pkg::REQ_DECLINE, MAC_D, '0, 32'h0A00_0250, 1'b1, 1'b1, 1'b1));
        send_msg(msg(dhcp_lte_pkg::REQ_IGNORE, '1, '1, '1, 1'b1, 1'b1, 1'b1));
    endtask

    // alternates fill-up and drain-down stretches so the table runs full and empty
    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++)
            send_msg(random_msg(((i / 50) % 2) == 1));
    endtask

    initial begin
        int shift;
        for (int i = 0; i < TBL; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_mac[i] = '0;
            tbl_ip[i] = '0;
        end
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        for (int i = 2; i < 28; i++) mac_pool[i] = dhcp_lte_pkg::MAC_W'({$urandom, $urandom});
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_offer_and_lookup();
        test_request_paths();
        test_release_decline_ignore();
        test_random_traffic(200);
        apply_settings('0, '0, 8'd0);
        test_random_traffic(200);
        apply_settings('1, '1, 8'd255);
        test_random_traffic(200);
        shift = $urandom_range(4, 12);
        apply_settings($urandom & (32'hFFFF_FFFF << shift), 32'hFFFF_FFFF << shift,
                       8'($urandom_range(1, 254)));
        test_random_traffic(200);
        settle();

        $display("%0d messages: discover %0d inform %0d request %0d release %0d decline %0d",
                 items_sent, type_sent[dhcp_lte_pkg::REQ_DISCOVER],
                 type_sent[dhcp_lte_pkg::REQ_INFORM], type_sent[dhcp_lte_pkg::REQ_REQUEST],
                 type_sent[dhcp_lte_pkg::REQ_RELEASE], type_sent[dhcp_lte_pkg::REQ_DECLINE]);
        $display("replies: none %0d offer %0d ack %0d nak %0d hit %0d miss %0d, full table %0d",
                 kind_seen[dhcp_lte_pkg::KIND_NONE], kind_seen[dhcp_lte_pkg::KIND_OFFER],
                 kind_seen[dhcp_lte_pkg::KIND_ACK], kind_seen[dhcp_lte_pkg::KIND_NAK],
                 kind_seen[dhcp_lte_pkg::KIND_HIT], kind_seen[dhcp_lte_pkg::KIND_MISS],
                 full_table_hits);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
